/* hw/rtl/jstc_pkg.sv */
// Shared types, codes and keyword tables for the JSON scalar token classifier.
package jstc_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last_char;
    } item_t;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_STRING = 3'd1;
    localparam logic [2:0] KIND_BOOL   = 3'd2;
    localparam logic [2:0] KIND_NULL   = 3'd3;
    localparam logic [2:0] KIND_INT    = 3'd4;
    localparam logic [2:0] KIND_DEC    = 3'd5;

    localparam logic [1:0] NS_INT  = 2'd0;
    localparam logic [1:0] NS_DEC  = 2'd1;
    localparam logic [1:0] NS_NONE = 2'd2;

    localparam int NUM_WORDS     = 5;
    localparam int WORD_NULL_BIT = 4;
    localparam int WORD_MAX_LEN  = 5;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // Keywords in order: yes, true, false, no, null; unused positions hold zero.
    localparam logic [NUM_WORDS-1:0][WORD_MAX_LEN-1:0][7:0] WORD_TEXT = '{
        '{8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E},
        '{8'h00, 8'h00, 8'h00, 8'h6F, 8'h6E},
        '{8'h65, 8'h73, 8'h6C, 8'h61, 8'h66},
        '{8'h00, 8'h65, 8'h75, 8'h72, 8'h74},
        '{8'h00, 8'h00, 8'h73, 8'h65, 8'h79}
    };

    localparam logic [NUM_WORDS-1:0][2:0] WORD_LEN = '{3'd4, 3'd2, 3'd5, 3'd4, 3'd3};

    function automatic logic [7:0] word_char(input int k, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        if (p < 3'(WORD_MAX_LEN)) begin
            ch = WORD_TEXT[k][p];
        end
        return ch;
    endfunction

endpackage

/* hw/rtl/jstc_scan.sv */
// Per-token state of the classifier and the type code of the token it closes.
module jstc_scan #(
    parameter int unsigned MAX_CHECKED_LEN = 65535
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  jstc_pkg::item_t item,
    input  logic            item_fire,
    output logic [2:0]      kind
);
    import jstc_pkg::*;

    logic [15:0]          pos_reg, pos_next;
    logic [7:0]           open_reg, open_next;
    logic [7:0]           close_reg, close_next;
    logic [NUM_WORDS-1:0] alive_reg, alive_next;
    logic [1:0]           ns_reg, ns_next;
    logic                 is_digit;
    logic                 found;

    assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);

    always_comb begin
        pos_next   = pos_reg;
        open_next  = open_reg;
        close_next = close_reg;
        alive_next = alive_reg;
        ns_next    = ns_reg;
        if (item.has_char) begin
            if (pos_reg == 16'd0) begin
                open_next = item.char_code;
            end
            close_next = item.char_code;
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (!((pos_reg < 16'(WORD_LEN[k]))
                      && (word_char(k, pos_reg[2:0]) == item.char_code))) begin
                    alive_next[k] = 1'b0;
                end
            end
            if ((pos_reg < 16'(MAX_CHECKED_LEN)) && ((ns_reg == NS_INT) || (ns_reg == NS_DEC))) begin
                priority if (is_digit) begin
                    ns_next = ns_reg;
                end else if ((item.char_code == CH_MINUS) && (pos_reg == 16'd0)) begin
                    ns_next = ns_reg;
                end else if ((item.char_code == CH_DOT) && (ns_reg == NS_INT)) begin
                    ns_next = NS_DEC;
                end else begin
                    ns_next = NS_NONE;
                end
            end
            if (pos_reg != 16'hFFFF) begin
                pos_next = pos_reg + 16'd1;
            end
        end
    end

    always_comb begin
        kind  = KIND_NONE;
        found = 1'b0;
        if (pos_next == 16'd0) begin
            found = 1'b1;
        end else if (pos_next >= 16'd2) begin
            if (((open_next == CH_DQUOTE) || (open_next == CH_SQUOTE))
                && (open_next == close_next)) begin
                kind  = KIND_STRING;
                found = 1'b1;
            end else begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (!found && alive_next[k] && (pos_next == 16'(WORD_LEN[k]))) begin
                        kind  = (k == WORD_NULL_BIT) ? KIND_NULL : KIND_BOOL;
                        found = 1'b1;
                    end
                end
            end
        end
        if (!found) begin
            if (ns_next == NS_INT) begin
                kind = KIND_INT;
            end else if (ns_next == NS_DEC) begin
                kind = KIND_DEC;
            end else begin
                kind = KIND_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (item_fire && item.last_char)) begin
            pos_reg   <= '0;
            open_reg  <= '0;
            close_reg <= '0;
            alive_reg <= '1;
            ns_reg    <= NS_INT;
        end else if (item_fire) begin
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            close_reg <= close_next;
            alive_reg <= alive_next;
            ns_reg    <= ns_next;
        end
    end

endmodule

/* hw/rtl/json_scalar_token_classifier_unit.sv */
// Top level of the JSON scalar token classifier: request register, token scanner, result register.
// The unit takes one character request per cycle, unless stalled as below, and gives one type code
// on the request that ends a token, from the result register after that request has passed from the
// input register through the token scanner. The input register holds a request back only
// when it ends a token while the result register still waits to be taken, so the sustained rate
// is one request per cycle whenever results are taken as they appear.
module json_scalar_token_classifier_unit #(
    parameter int unsigned MAX_CHECKED_LEN = 65535
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_has_char,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_kind
);
    import jstc_pkg::*;

    item_t      in_reg;
    logic       in_valid_reg, in_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] kind_reg;
    logic [2:0] scan_kind;
    logic       advance;
    logic       s_fire;

    assign advance = in_valid_reg && (!in_reg.last_char || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = (advance && in_reg.last_char) || (out_valid_reg && !m_ready);

    jstc_scan #(
        .MAX_CHECKED_LEN(MAX_CHECKED_LEN)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (in_reg),
        .item_fire(advance),
        .kind     (scan_kind)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg.char_code <= s_char_code;
            in_reg.has_char  <= s_has_char;
            in_reg.last_char <= s_last_char;
        end
        if (advance && in_reg.last_char) begin
            kind_reg <= scan_kind;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_token_kind = kind_reg;

endmodule

/* hw/rtl/jstc_checker.sv */
// Port-level checks for the JSON scalar token classifier and their binding to the top level.
module jstc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_token_kind
);
    import jstc_pkg::*;

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind))
        else $error("Stalled result changed or dropped.");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_token_kind <= KIND_DEC))
        else $error("Result carries an undefined type code.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result shown right after reset.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("Request side stalled without a waiting result.");

endmodule

bind json_scalar_token_classifier_unit jstc_checker u_jstc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_token_kind(m_token_kind)
);

/* bench/tb_top.sv */
// Self-checking testbench for the JSON scalar token classifier unit, with a scoreboard class.
module tb_top;
    import jstc_pkg::*;

    localparam int unsigned CHECK_LIMIT  = 65535;
    localparam int          RANDOM_ITEMS = 850;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          CYCLE_LIMIT  = 1000000;

    class token_scoreboard;
        string       words[NUM_WORDS] = '{"yes", "true", "false", "no", "null"};
        logic [15:0] seen_len    = '0;
        logic [7:0]  first_byte  = '0;
        logic [7:0]  recent_byte = '0;
        logic [4:0]  word_live   = '1;
        logic [1:0]  num_state   = NS_INT;
        logic [2:0]  kinds_due[$];
        int          checked = 0;
        int          errors  = 0;

        function void clear_token();
            seen_len    = '0;
            first_byte  = '0;
            recent_byte = '0;
            word_live   = '1;
            num_state   = NS_INT;
        endfunction

        function void absorb_byte(logic [7:0] c);
            int pos;
            pos = int'(seen_len);
            if (pos == 0) begin
                first_byte = c;
            end
            recent_byte = c;
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (!(pos < words[k].len() && words[k][pos] == c)) begin
                    word_live[k] = 1'b0;
                end
            end
            if (pos < CHECK_LIMIT && (num_state == NS_INT || num_state == NS_DEC)) begin
                if (!(c >= CH_ZERO && c <= CH_NINE) && !(c == CH_MINUS && pos == 0)) begin
                    if (c == CH_DOT && num_state == NS_INT) begin
                        num_state = NS_DEC;
                    end else begin
                        num_state = NS_NONE;
                    end
                end
            end
            if (seen_len != 16'hFFFF) begin
                seen_len++;
            end
        endfunction

        function logic [2:0] token_class();
            if (seen_len == 0) begin
                return KIND_NONE;
            end
            if (seen_len >= 2) begin
                if ((first_byte == CH_DQUOTE || first_byte == CH_SQUOTE) &&
                    first_byte == recent_byte) begin
                    return KIND_STRING;
                end
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (word_live[k] && int'(seen_len) == words[k].len()) begin
                        return (k == WORD_NULL_BIT) ? KIND_NULL : KIND_BOOL;
                    end
                end
            end
            if (num_state == NS_INT) begin
                return KIND_INT;
            end
            if (num_state == NS_DEC) begin
                return KIND_DEC;
            end
            return KIND_NONE;
        endfunction

        function void note_request(logic [7:0] c, logic h, logic l);
            if (h) begin
                absorb_byte(c);
            end
            if (l) begin
                kinds_due.push_back(token_class());
                clear_token();
            end
        endfunction

        function void check_result(logic [2:0] kind);
            logic [2:0] want;
            if (kinds_due.size() == 0) begin
                $display("%0t: token_kind expected none, actual %0d", $time, kind);
                errors++;
            end else begin
                want = kinds_due.pop_front();
                checked++;
                if (want !== kind) begin
                    $display("%0t: token_kind expected %0d, actual %0d", $time, want, kind);
                    errors++;
                end
            end
        endfunction

        function int waiting();
            return kinds_due.size();
        endfunction
    endclass

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code  = '0;
    logic       s_has_char   = 1'b0;
    logic       s_last_char  = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [2:0] m_token_kind;

    logic       hold_go      = 1'b0;
    logic       hold_done    = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         item_count    = 0;
    int         token_count   = 0;
    int         cycle_count   = 0;
    logic [7:0] token_text[$];

    token_scoreboard sb = new;

    json_scalar_token_classifier_unit #(
        .MAX_CHECKED_LEN(CHECK_LIMIT)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_has_char  (s_has_char),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_token_kind(m_token_kind)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("json_scalar_token_classifier_unit test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_char_code, s_has_char, s_last_char);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_token_kind);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_done <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_req(input logic [7:0] c, input logic h, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_has_char  <= h;
        s_last_char <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (h || l) begin
            item_count++;
        end
    endtask

    task automatic send_token(input bit close_bare);
        for (int i = 0; i < token_text.size(); i++) begin
            if ($urandom_range(99) < 4) begin
                send_req(8'($urandom), 1'b0, 1'b0);
            end
            send_req(token_text[i], 1'b1, !close_bare && i == token_text.size() - 1);
        end
        if (close_bare || token_text.size() == 0) begin
            send_req(8'($urandom), 1'b0, 1'b1);
        end
        token_count++;
    endtask

    task automatic send_text(input string s, input bit close_bare);
        token_text.delete();
        for (int i = 0; i < s.len(); i++) begin
            token_text.push_back(s[i]);
        end
        send_token(close_bare);
    endtask

    task automatic build_random_token(output bit close_bare);
        int         n;
        int         w;
        logic [7:0] q;
        token_text.delete();
        case ($urandom_range(9))
            0, 1: begin
                w = $urandom_range(NUM_WORDS - 1);
                for (int i = 0; i < sb.words[w].len(); i++) begin
                    token_text.push_back(sb.words[w][i]);
                end
                case ($urandom_range(5))
                    0: void'(token_text.pop_back());
                    1: token_text.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    2: token_text[$urandom_range(token_text.size() - 1)] = 8'($urandom);
                    default: ;
                endcase
            end
            2, 3: begin
                q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                token_text.push_back(q);
                n = $urandom_range(5);
                repeat (n) token_text.push_back(8'($urandom_range(32, 126)));
                case ($urandom_range(4))
                    0: token_text.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                    1: token_text.push_back(8'($urandom));
                    default: token_text.push_back(q);
                endcase
            end
            4, 5, 6: begin
                if ($urandom_range(1)) begin
                    token_text.push_back(CH_MINUS);
                end
                n = $urandom_range(6);
                repeat (n) token_text.push_back(CH_ZERO + 8'($urandom_range(9)));
                n = ($urandom_range(3) == 0) ? 2 : $urandom_range(1);
                repeat (n) token_text.insert($urandom_range(token_text.size()), CH_DOT);
                if ($urandom_range(6) == 0) begin
                    q = $urandom_range(1) ? CH_MINUS : 8'($urandom);
                    token_text.insert($urandom_range(token_text.size()), q);
                end
            end
            7: begin
                case ($urandom_range(5))
                    0: token_text.push_back(CH_MINUS);
                    1: token_text.push_back(CH_DOT);
                    2: token_text.push_back(CH_DQUOTE);
                    3: token_text.push_back(CH_SQUOTE);
                    4: token_text.push_back(CH_ZERO + 8'($urandom_range(9)));
                    default: token_text.push_back(8'($urandom));
                endcase
            end
            8: begin
                n = $urandom_range(1, 8);
                repeat (n) token_text.push_back(8'($urandom));
            end
            default: ;
        endcase
        close_bare = ($urandom_range(4) == 0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.waiting() != 0) @(posedge aclk);
    endtask

    initial begin
        bit bare;
        int random_start;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("", 1'b1);
        send_req(8'hA5, 1'b0, 1'b0);
        send_text("-", 1'b0);
        send_text(".", 1'b0);
        send_text("yes", 1'b0);
        send_text("true", 1'b0);
        send_text("false", 1'b0);
        send_text("no", 1'b0);
        send_text("null", 1'b0);
        send_text("\"\"", 1'b0);
        send_text("''", 1'b0);
        send_text("\"ab'", 1'b0);
        send_text("'x'", 1'b0);
        send_text("\"", 1'b0);
        send_text("'", 1'b1);
        send_text("true", 1'b1);
        send_text("nul", 1'b0);
        send_text("nulls", 1'b0);
        send_text("-12.5", 1'b0);
        send_text("1.2.3", 1'b0);
        send_text("1-2", 1'b0);
        send_text("007", 1'b0);
        send_text("9/", 1'b0);
        send_text("9:", 1'b1);
        token_text.delete();
        token_text.push_back(8'h00);
        token_text.push_back(8'hFF);
        send_token(1'b0);
        drain_results();

        random_start = item_count;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_go <= 1'b1;
                end
            endcase
            while (item_count - random_start < (phase + 1) * RANDOM_ITEMS / 3) begin
                build_random_token(bare);
                send_token(bare);
            end
            drain_results();
        end

        repeat (20) @(posedge aclk);
        $display("Sent %0d tokens in %0d requests: directed keyword, string and number cases,",
                 token_count, item_count);
        $display("and random tokens under sender idling, receiver idling and a long output stall.");
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("json_scalar_token_classifier_unit test passed");
        end else begin
            $display("json_scalar_token_classifier_unit test failed");
        end
        $finish;
    end

endmodule
